// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

  // number format
  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int TRIG_BITS  = 15;

  // fixed field widths
  localparam int POS_W     = 16;
  localparam int HEAD_W    = 12;
  localparam int SPEED_W   = 8;
  localparam int AREA_W    = 12;
  localparam int HIT_W     = 2;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 1'd1;
  localparam logic [AREA_W-1:0]    AREA_RESET      = AREA_W'(32);

  // derived widths
  localparam int QUARTER  = 1 << (ANGLE_BITS - 2);
  localparam int IDX_W    = ANGLE_BITS - 1;
  localparam int MAG_W    = TRIG_BITS + 1;
  localparam int PROD_W   = MAG_W + SPEED_W;
  localparam int ROUND_SH = TRIG_BITS - FRAC_BITS;
  localparam int ROUND_HALF = (ROUND_SH > 0) ? (1 << (ROUND_SH - 1)) : 0;
  localparam int DELTA_W  = SPEED_W + FRAC_BITS;
  localparam int SUM_W    = ((DELTA_W > POS_W) ? DELTA_W : POS_W) + 2;
  localparam int WALL_W   = AREA_W + FRAC_BITS;
  localparam int REF_W    = (((WALL_W + 1) > SUM_W) ? (WALL_W + 1) : SUM_W) + 2;

  localparam logic [ANGLE_BITS-1:0] QUARTER_ANG   = ANGLE_BITS'(QUARTER);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN_ANG = ANGLE_BITS'(2 * QUARTER);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER];

  // sin(r * pi/2 / QUARTER) in q30 by taylor series, rounded to TRIG_BITS
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(r) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    sum = (sum + (64'sd1 << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS);
    return MAG_W'(sum);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i <= QUARTER; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

endpackage

// ===== hdl/bpa_trig_rom.sv =====
module bpa_trig_rom (
  input  logic                              clk,
  input  logic                              en,
  input  logic [bpa_pkg::ANGLE_BITS-1:0]    angle,
  output logic [bpa_pkg::MAG_W-1:0]         cos_mag,
  output logic                              cos_neg,
  output logic [bpa_pkg::MAG_W-1:0]         sin_mag,
  output logic                              sin_neg
);

  localparam bpa_pkg::sine_tab_t SINE_TAB = bpa_pkg::build_sine_tab();
  localparam int A = bpa_pkg::ANGLE_BITS;

  logic [A-1:0]              cos_angle;
  logic [bpa_pkg::IDX_W-1:0] sin_idx;
  logic [bpa_pkg::IDX_W-1:0] cos_idx;

  // quadrant folding onto the quarter-wave table
  always_comb begin
    cos_angle = angle + bpa_pkg::QUARTER_ANG;
    sin_idx = angle[A-2] ?
              bpa_pkg::IDX_W'(bpa_pkg::QUARTER) - bpa_pkg::IDX_W'(angle[A-3:0]) :
              bpa_pkg::IDX_W'(angle[A-3:0]);
    cos_idx = cos_angle[A-2] ?
              bpa_pkg::IDX_W'(bpa_pkg::QUARTER) - bpa_pkg::IDX_W'(cos_angle[A-3:0]) :
              bpa_pkg::IDX_W'(cos_angle[A-3:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_mag <= SINE_TAB[sin_idx];
      cos_mag <= SINE_TAB[cos_idx];
      sin_neg <= angle[A-1];
      cos_neg <= cos_angle[A-1];
    end
  end

endmodule

// ===== hdl/bpa_move.sv =====
module bpa_move (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [bpa_pkg::MAG_W-1:0]              mag,
  input  logic                                   neg,
  input  logic [bpa_pkg::SPEED_W-1:0]            speed,
  input  logic [bpa_pkg::POS_W-1:0]              pos,
  output logic signed [bpa_pkg::SUM_W-1:0]       sum
);

  logic [bpa_pkg::PROD_W-1:0]        prod;
  logic                              prod_neg;
  logic [bpa_pkg::POS_W-1:0]         prod_pos;
  logic [bpa_pkg::PROD_W:0]          rnd_full;
  logic [bpa_pkg::DELTA_W-1:0]       delta;
  logic signed [bpa_pkg::SUM_W-1:0]  pos_ext;
  logic signed [bpa_pkg::SUM_W-1:0]  delta_ext;
  logic signed [bpa_pkg::SUM_W-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= bpa_pkg::PROD_W'(mag) * bpa_pkg::PROD_W'(speed);
      prod_neg <= neg;
      prod_pos <= pos;
    end
  end

  // round half away from zero on the magnitude, then apply the sign
  always_comb begin
    rnd_full  = {1'b0, prod} + (bpa_pkg::PROD_W + 1)'(bpa_pkg::ROUND_HALF);
    delta     = bpa_pkg::DELTA_W'(rnd_full >> bpa_pkg::ROUND_SH);
    pos_ext   = $signed(bpa_pkg::SUM_W'(prod_pos));
    delta_ext = $signed(bpa_pkg::SUM_W'(delta));
    sum_next  = prod_neg ? (pos_ext - delta_ext) : (pos_ext + delta_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== hdl/bpa_bounce.sv =====
module bpa_bounce (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bpa_pkg::SUM_W-1:0]    sum,
  input  logic [bpa_pkg::AREA_W-1:0]          area,
  output logic [bpa_pkg::POS_W-1:0]           pos,
  output logic                                hit,
  output logic                                odd
);

  localparam int R = bpa_pkg::REF_W;
  localparam logic signed [R-1:0] POS_MAX = R'((1 << bpa_pkg::POS_W) - 1);

  logic signed [R-1:0] sum_ext;
  logic signed [R-1:0] p1_next;
  logic signed [R-1:0] p1;
  logic                low;
  logic signed [R-1:0] wall;
  logic                over;
  logic signed [R-1:0] p2;
  logic signed [R-1:0] p3;

  // first half: fold off the wall at zero
  always_comb begin
    sum_ext = R'(sum);
    p1_next = (sum < 0) ? -sum_ext : sum_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= p1_next;
      low <= (sum < 0);
    end
  end

  // second half: fold off the far wall, then saturate
  always_comb begin
    wall = $signed(R'(area) << bpa_pkg::FRAC_BITS);
    over = (p1 >= wall);
    p2   = over ? ((wall <<< 1) - p1) : p1;
    p3   = p2;
    if (p3 < 0) p3 = '0;
    if (p3 > wall) p3 = wall;
    if (p3 > POS_MAX) p3 = POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= bpa_pkg::POS_W'(p3);
      hit <= low | over;
      odd <= low ^ over;
    end
  end

endmodule

// ===== hdl/bouncing_point_advance.sv =====
// bouncing point advance: one move-and-reflect step of a point in a box
// input beat: pos_x, pos_y (1/16 pixel), heading (4096 per turn), step_speed
// (pixels); taken when in_valid and in_ready are both high
// output beat: new_x, new_y, new_heading and hit_wall (bit0 x wall, bit1 y
// wall), one per input beat, in order, on out_valid / out_ready
// config beat: cfg_index 0 writes area_width, 1 writes area_height, both in
// whole pixels; cfg_ready is always high, write only while the block is idle
// throughput: one beat per cycle unless the pipe holds; stages are sine rom read, multiply,
// round and add, fold at zero, fold at far wall and saturate
// when out_ready is low with a result waiting, the whole pipe holds and
// in_ready drops; nothing is lost or repeated
// reset: rst (sync, active high) empties the pipe and sets both area
// registers to 32
module bouncing_point_advance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bpa_pkg::POS_W-1:0]           pos_x,
  input  logic [bpa_pkg::POS_W-1:0]           pos_y,
  input  logic [bpa_pkg::HEAD_W-1:0]          heading,
  input  logic [bpa_pkg::SPEED_W-1:0]         step_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bpa_pkg::POS_W-1:0]           new_x,
  output logic [bpa_pkg::POS_W-1:0]           new_y,
  output logic [bpa_pkg::HEAD_W-1:0]          new_heading,
  output logic [bpa_pkg::HIT_W-1:0]           hit_wall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpa_pkg::AREA_W-1:0]          cfg_data
);

  localparam int A = bpa_pkg::ANGLE_BITS;

  logic [bpa_pkg::AREA_W-1:0] area_width;
  logic [bpa_pkg::AREA_W-1:0] area_height;

  logic       adv;
  logic [4:0] vld;

  logic [A-1:0] angle_in;
  logic [A-1:0] head1;
  logic [A-1:0] head2;
  logic [A-1:0] head3;
  logic [A-1:0] head4;
  logic [A-1:0] head5;

  logic [bpa_pkg::POS_W-1:0]   x1;
  logic [bpa_pkg::POS_W-1:0]   y1;
  logic [bpa_pkg::SPEED_W-1:0] speed1;

  logic [bpa_pkg::MAG_W-1:0] cos_mag;
  logic [bpa_pkg::MAG_W-1:0] sin_mag;
  logic                      cos_neg;
  logic                      sin_neg;

  logic signed [bpa_pkg::SUM_W-1:0] sum_x;
  logic signed [bpa_pkg::SUM_W-1:0] sum_y;

  logic hx;
  logic hy;
  logic odd_x;
  logic odd_y;

  logic [A-1:0] head_fx;
  logic [A-1:0] head_fy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= bpa_pkg::AREA_RESET;
      area_height <= bpa_pkg::AREA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpa_pkg::REG_AREA_WIDTH:  area_width  <= cfg_data;
        bpa_pkg::REG_AREA_HEIGHT: area_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // single stall signal for the whole pipe
  assign adv       = !vld[4] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[4];
  assign angle_in  = A'(heading);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head1  <= angle_in;
      x1     <= pos_x;
      y1     <= pos_y;
      speed1 <= step_speed;
      head2  <= head1;
      head3  <= head2;
      head4  <= head3;
      head5  <= head4;
    end
  end

  bpa_trig_rom u_rom (
    .clk     (clk),
    .en      (adv),
    .angle   (angle_in),
    .cos_mag (cos_mag),
    .cos_neg (cos_neg),
    .sin_mag (sin_mag),
    .sin_neg (sin_neg)
  );

  bpa_move u_move_x (
    .clk   (clk),
    .en    (adv),
    .mag   (cos_mag),
    .neg   (cos_neg),
    .speed (speed1),
    .pos   (x1),
    .sum   (sum_x)
  );

  bpa_move u_move_y (
    .clk   (clk),
    .en    (adv),
    .mag   (sin_mag),
    .neg   (sin_neg),
    .speed (speed1),
    .pos   (y1),
    .sum   (sum_y)
  );

  bpa_bounce u_bounce_x (
    .clk  (clk),
    .en   (adv),
    .sum  (sum_x),
    .area (area_width),
    .pos  (new_x),
    .hit  (hx),
    .odd  (odd_x)
  );

  bpa_bounce u_bounce_y (
    .clk  (clk),
    .en   (adv),
    .sum  (sum_y),
    .area (area_height),
    .pos  (new_y),
    .hit  (hy),
    .odd  (odd_y)
  );

  // two reflections on one axis cancel, so only the parity matters
  always_comb begin
    head_fx     = odd_x ? (bpa_pkg::HALF_TURN_ANG - head5) : head5;
    head_fy     = odd_y ? (A'(0) - head_fx) : head_fx;
    new_heading = bpa_pkg::HEAD_W'(head_fy);
    hit_wall    = {hy, hx};
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = bpa_pkg::ANGLE_BITS;
  localparam int FRAC_BITS  = bpa_pkg::FRAC_BITS;
  localparam int TRIG_BITS  = bpa_pkg::TRIG_BITS;
  localparam int POS_W      = bpa_pkg::POS_W;
  localparam int HEAD_W     = bpa_pkg::HEAD_W;
  localparam int SPEED_W    = bpa_pkg::SPEED_W;
  localparam int AREA_W     = bpa_pkg::AREA_W;
  localparam int HIT_W      = bpa_pkg::HIT_W;
  localparam int CFG_IDX_W  = bpa_pkg::CFG_IDX_W;

  localparam int TURN_UNITS   = 1 << ANGLE_BITS;
  localparam int QUARTER_TURN = 1 << (ANGLE_BITS - 2);
  localparam int X_FOLD_BASE  = TURN_UNITS + TURN_UNITS / 2;
  localparam int Y_FOLD_BASE  = TURN_UNITS;
  localparam int POS_MAX      = (1 << POS_W) - 1;
  localparam int AREA_MAX     = (1 << AREA_W) - 1;
  localparam int SPEED_MAX    = (1 << SPEED_W) - 1;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint          UNIT_Q30    = 64'sd1 << 30;
  localparam logic [HIT_W-1:0] HIT_X = 2'b01;
  localparam logic [HIT_W-1:0] HIT_Y = 2'b10;

  // idle percentages per side
  localparam int IDLE_LIGHT = 14;
  localparam int IDLE_HEAVY = 50;
  localparam int IDLE_NONE  = 0;

  localparam int RANDOM_PER_PHASE = 138;
  localparam int NUM_PHASES       = 8;

  typedef struct {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] head;
    logic [HIT_W-1:0]  hit;
  } step_result_t;

  typedef struct {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [HEAD_W-1:0]  head;
    logic [SPEED_W-1:0] speed;
  } point_t;

  class point_scoreboard;
    int           sine_q[0:QUARTER_TURN];
    int           area_w;
    int           area_h;
    int           errors;
    step_result_t pending_steps[$];

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int r = 0; r <= QUARTER_TURN; r++) begin
        x = r;
        x = (x * PI_HALF_Q30) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        // taylor series up to the x^15 term, truncating each step
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > UNIT_Q30) acc = UNIT_Q30;
        sine_q[r] = int'((acc + (64'sd1 << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS));
      end
      area_w = int'(bpa_pkg::AREA_RESET);
      area_h = int'(bpa_pkg::AREA_RESET);
      errors = 0;
    endfunction

    function void set_area(logic [CFG_IDX_W-1:0] idx, logic [AREA_W-1:0] val);
      if (idx == bpa_pkg::REG_AREA_WIDTH) area_w = val;
      else if (idx == bpa_pkg::REG_AREA_HEIGHT) area_h = val;
    endfunction

    function int sine_of(int a);
      int q;
      int r;
      a = a & (TURN_UNITS - 1);
      q = a >> (ANGLE_BITS - 2);
      r = a & (QUARTER_TURN - 1);
      case (q)
        0: return sine_q[r];
        1: return sine_q[QUARTER_TURN - r];
        2: return -sine_q[r];
        default: return -sine_q[QUARTER_TURN - r];
      endcase
    endfunction

    // speed * trig scaled to position units, ties away from zero
    function longint step_delta(int speed, int trig);
      longint mag;
      mag = longint'(trig < 0 ? -trig : trig) * speed;
      mag = (mag + (64'sd1 << (TRIG_BITS - FRAC_BITS - 1))) >>> (TRIG_BITS - FRAC_BITS);
      return (trig < 0) ? -mag : mag;
    endfunction

    function longint fold(input longint p, input longint wall, input int base,
                          inout int hd, inout bit hit);
      if (p < 0) begin
        p = -p;
        hd = (base - hd) & (TURN_UNITS - 1);
        hit = 1'b1;
      end
      if (p >= wall) begin
        p = 2 * wall - p;
        hd = (base - hd) & (TURN_UNITS - 1);
        hit = 1'b1;
      end
      if (p < 0) p = 0;
      if (p > wall) p = wall;
      if (p > POS_MAX) p = POS_MAX;
      return p;
    endfunction

    function void note_point(point_t pt);
      longint       px;
      longint       py;
      int           hd;
      bit           hx;
      bit           hy;
      step_result_t res;
      hd = pt.head;
      hx = 1'b0;
      hy = 1'b0;
      px = longint'(pt.x) + step_delta(pt.speed, sine_of(hd + QUARTER_TURN));
      py = longint'(pt.y) + step_delta(pt.speed, sine_of(hd));
      px = fold(px, longint'(area_w) << FRAC_BITS, X_FOLD_BASE, hd, hx);
      py = fold(py, longint'(area_h) << FRAC_BITS, Y_FOLD_BASE, hd, hy);
      res.x = px[POS_W-1:0];
      res.y = py[POS_W-1:0];
      res.head = hd[HEAD_W-1:0];
      res.hit = (hx ? HIT_X : '0) | (hy ? HIT_Y : '0);
      pending_steps.insert(pending_steps.size(), res);
    endfunction

    function void check_result(step_result_t got);
      step_result_t exp_r;
      if (pending_steps.size() == 0) begin
        $error("result beat with nothing expected: x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      exp_r = pending_steps.pop_front();
      if (got.x !== exp_r.x) begin
        $error("new_x: expected %0d, got %0d", exp_r.x, got.x);
        errors++;
      end
      if (got.y !== exp_r.y) begin
        $error("new_y: expected %0d, got %0d", exp_r.y, got.y);
        errors++;
      end
      if (got.head !== exp_r.head) begin
        $error("new_heading: expected %0d, got %0d", exp_r.head, got.head);
        errors++;
      end
      if (got.hit !== exp_r.hit) begin
        $error("hit_wall: expected %0d, got %0d", exp_r.hit, got.hit);
        errors++;
      end
    endfunction

    function int pending();
      return pending_steps.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [HEAD_W-1:0]    heading;
  logic [SPEED_W-1:0]   step_speed;
  logic                 out_valid;
  logic                 out_ready;
  logic [POS_W-1:0]     new_x;
  logic [POS_W-1:0]     new_y;
  logic [HEAD_W-1:0]    new_heading;
  logic [HIT_W-1:0]     hit_wall;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [AREA_W-1:0]    cfg_data;

  point_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              cur_w;
  int              cur_h;

  bouncing_point_advance u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .step_speed  (step_speed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_x       (new_x),
    .new_y       (new_y),
    .new_heading (new_heading),
    .hit_wall    (hit_wall),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    step_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.x = new_x;
      got.y = new_y;
      got.head = new_heading;
      got.hit = hit_wall;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_point(point_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pos_x = pt.x;
    pos_y = pt.y;
    heading = pt.head;
    step_speed = pt.speed;
    do @(posedge clk); while (!in_ready);
    sb.note_point(pt);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_area(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[AREA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_area(idx, val[AREA_W-1:0]);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [POS_W-1:0] clamp_pos(int p);
    if (p < 0) return '0;
    if (p > POS_MAX) return POS_MAX[POS_W-1:0];
    return p[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pick_coord(int area, int kind);
    int wall;
    int off;
    wall = area << FRAC_BITS;
    case (kind)
      0: return POS_W'($urandom);
      1: return clamp_pos($urandom_range(wall, 0));
      default: begin
        // close to one of the two walls
        off = $urandom_range(SPEED_MAX << FRAC_BITS, 0);
        return clamp_pos($urandom_range(1) ? wall - off : off);
      end
    endcase
  endfunction

  function automatic point_t random_point();
    point_t pt;
    int     sel;
    int     kind;
    sel = $urandom_range(9);
    kind = (sel < 2) ? 0 : (sel < 6) ? 1 : 2;
    pt.x = pick_coord(cur_w, kind);
    pt.y = pick_coord(cur_h, kind);
    pt.head = HEAD_W'($urandom);
    if (kind == 1 && $urandom_range(3) != 0) pt.speed = SPEED_W'($urandom_range(15));
    else pt.speed = SPEED_W'($urandom);
    return pt;
  endfunction

  initial begin
    point_t directed[$];
    int     phase_w[NUM_PHASES];
    int     phase_h[NUM_PHASES];

    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = '0;
    pos_y = '0;
    heading = '0;
    step_speed = '0;
    cfg_valid = 1'b0;
    cfg_index = bpa_pkg::REG_AREA_WIDTH;
    cfg_data = '0;
    send_idle_pct = IDLE_LIGHT;
    recv_idle_pct = IDLE_HEAVY;
    cur_w = int'(bpa_pkg::AREA_RESET);
    cur_h = int'(bpa_pkg::AREA_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset area is 32 x 32 pixels, walls at 512 in position units
    directed = '{
      '{16'd256, 16'd256, 12'd0, 8'd0},       // no move
      '{16'd256, 16'd256, 12'd0, 8'd10},      // each axis direction
      '{16'd256, 16'd256, 12'd1024, 8'd10},
      '{16'd256, 16'd256, 12'd2048, 8'd10},
      '{16'd256, 16'd256, 12'd3072, 8'd10},
      '{16'd256, 16'd256, 12'd4095, 8'd255},  // overshoot far wall, saturate
      '{16'd0, 16'd0, 12'd0, 8'd0},
      '{16'd65535, 16'd65535, 12'd1, 8'd0},   // starts far outside
      '{16'd16, 16'd256, 12'd2048, 8'd3},     // near x wall
      '{16'd500, 16'd256, 12'd0, 8'd3},       // far x wall
      '{16'd256, 16'd16, 12'd3072, 8'd3},     // near y wall
      '{16'd256, 16'd500, 12'd1024, 8'd3},    // far y wall
      '{16'd8, 16'd8, 12'd2560, 8'd5},        // corner at origin
      '{16'd504, 16'd504, 12'd512, 8'd5},     // far corner
      '{16'd512, 16'd512, 12'd0, 8'd0},       // sitting exactly on the wall
      '{16'd256, 16'd256, 12'd512, 8'd255},
      '{16'd0, 16'd65535, 12'd4095, 8'd255},
      '{16'd65535, 16'd0, 12'd2047, 8'd128},
      '{16'd256, 16'd256, 12'd1, 8'd1},
      '{16'd256, 16'd256, 12'd3071, 8'd7}
    };
    foreach (directed[i]) send_point(directed[i]);
    drain();

    // extremes first, zero-sized area included, then random sizes, then 77 x 300
    phase_w = '{1, AREA_MAX, 0, AREA_MAX, 1, 0, 0, 77};
    phase_h = '{1, AREA_MAX, 0, 1, AREA_MAX, 0, 0, 300};
    phase_w[5] = $urandom_range(AREA_MAX, 1);
    phase_h[5] = $urandom_range(AREA_MAX, 1);
    phase_w[6] = $urandom_range(AREA_MAX, 1);
    phase_h[6] = $urandom_range(AREA_MAX, 1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = IDLE_LIGHT;
        recv_idle_pct = IDLE_HEAVY;
      end else if (ph < 6) begin
        send_idle_pct = IDLE_HEAVY;
        recv_idle_pct = IDLE_LIGHT;
      end else begin
        send_idle_pct = IDLE_NONE;
        recv_idle_pct = IDLE_NONE;
      end
      write_area(bpa_pkg::REG_AREA_WIDTH, phase_w[ph]);
      write_area(bpa_pkg::REG_AREA_HEIGHT, phase_h[ph]);
      cur_w = phase_w[ph];
      cur_h = phase_h[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_point(random_point());
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bpa_pkg.sv
hdl/bpa_trig_rom.sv
hdl/bpa_move.sv
hdl/bpa_bounce.sv
hdl/bouncing_point_advance.sv
verif/tb.sv
